FILE: src/b36_pkg.sv
// ----------------------------------------------------------------------------
// b36_pkg
// Shared types and constants for the base-36 text decoder: character codes,
// the overflow guard value and the running decode state.
// ----------------------------------------------------------------------------
package b36_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned DIGIT_W = 6;

    typedef logic [VALUE_W-1:0] b36_value_t;
    typedef logic [DIGIT_W-1:0] b36_digit_t;
    typedef logic [7:0]         b36_char_t;

    // Smallest accumulator that no longer takes one more digit (guard against wrapping)
    localparam b36_value_t B36_LIMIT = 64'd512409557603000000;

    localparam b36_char_t CHAR_SPACE = 8'h20;
    localparam b36_char_t CHAR_UNDER = 8'h5F;
    localparam b36_char_t CHAR_COMMA = 8'h2C;
    localparam b36_char_t CHAR_0     = 8'h30;
    localparam b36_char_t CHAR_9     = 8'h39;
    localparam b36_char_t CHAR_LA    = 8'h61;
    localparam b36_char_t CHAR_LZ    = 8'h7A;
    localparam b36_char_t CHAR_UA    = 8'h41;
    localparam b36_char_t CHAR_UZ    = 8'h5A;

    // Digit value of the letter 'a' / 'A'
    localparam b36_char_t LETTER_BASE = 8'd10;

    // Running decode state of one string
    typedef struct packed {
        b36_value_t acc;
        logic       err;
    } b36_state_t;

endpackage

FILE: src/b36_accum_step.sv
// ----------------------------------------------------------------------------
// b36_accum_step
// One decode step: classify a character and fold it into the running value,
// raising the sticky error on a bad character or on a digit past the guard.
// ----------------------------------------------------------------------------
module b36_accum_step (
    input  b36_pkg::b36_char_t  char_byte,
    input  logic                char_present,
    input  b36_pkg::b36_state_t cur,
    output b36_pkg::b36_state_t nxt
);
    import b36_pkg::*;

    logic       is_skip;
    logic       is_num;
    logic       is_low;
    logic       is_up;
    b36_char_t  digit_full;
    b36_digit_t digit;
    b36_value_t acc_x36;

    // Classify the character
    assign is_skip = (char_byte == CHAR_SPACE) || (char_byte == CHAR_UNDER)
                  || (char_byte == CHAR_COMMA);
    assign is_num  = (char_byte >= CHAR_0)  && (char_byte <= CHAR_9);
    assign is_low  = (char_byte >= CHAR_LA) && (char_byte <= CHAR_LZ);
    assign is_up   = (char_byte >= CHAR_UA) && (char_byte <= CHAR_UZ);

    always_comb begin
        priority if (is_num) begin
            digit_full = char_byte - CHAR_0;
        end else if (is_low) begin
            digit_full = char_byte - CHAR_LA + LETTER_BASE;
        end else begin
            digit_full = char_byte - CHAR_UA + LETTER_BASE;
        end
    end
    assign digit = digit_full[DIGIT_W-1:0];

    // acc * 36 as two shifted copies
    assign acc_x36 = (cur.acc << 5) + (cur.acc << 2);

    // Fold the character into the state
    always_comb begin
        nxt = cur;
        if (char_present && !is_skip) begin
            if (!(is_num || is_low || is_up) || (cur.acc >= B36_LIMIT)) begin
                nxt.err = 1'b1;
            end else if (!cur.err) begin
                nxt.acc = acc_x36 + b36_value_t'(digit);
            end
        end
    end

endmodule

FILE: src/base36_text_decoder.sv
// ----------------------------------------------------------------------------
// base36_text_decoder
// Decodes a base-36 text string, one character per word, most significant
// digit first, into a 64-bit unsigned value with a sticky error flag.
// ----------------------------------------------------------------------------
//  channel | direction | tdata            | tuser            | tlast
//  s_      | in        | [7:0] char_byte  | [0] char_present | is_last
//  m_      | out       | [63:0] value     | [0] bad_input    | -
//
//  One character word per cycle unless a string-ending word waits on a stalled
//  result. The result register is loaded as the word that ends the string
//  leaves the input register; the multiply-by-36 and add loop is combinational.
//  Reset (aresetn low, synchronous) clears both stages and the decode state.
//  A stalled result holds only words that end a string; other words keep
//  flowing past a pending result.
// ----------------------------------------------------------------------------
module base36_text_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic [0:0]  s_tuser,   // [0] char_present
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] decoded_value
    output logic [0:0]  m_tuser    // [0] bad_input
);
    import b36_pkg::*;

    logic       in_vld_reg;
    b36_char_t  in_byte_reg;
    logic       in_present_reg;
    logic       in_last_reg;
    b36_state_t state_reg;
    b36_state_t state_next;
    logic       out_vld_reg;
    b36_value_t out_value_reg;
    logic       out_bad_reg;
    logic       advance;
    logic       in_take;
    logic       out_take;

    // Advance a word unless it ends a string and the result slot is full
    assign advance  = in_vld_reg && (!in_last_reg || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign out_take = advance && in_last_reg;

    b36_accum_step u_step (
        .char_byte    (in_byte_reg),
        .char_present (in_present_reg),
        .cur          (state_reg),
        .nxt          (state_next)
    );

    // Control and decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end else begin
            if (in_take) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (out_take) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (advance) begin
                state_reg <= in_last_reg ? '0 : state_next;
            end
        end
    end

    // Capture input word and result payload
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser[0];
            in_last_reg    <= s_tlast;
        end
        if (out_take) begin
            out_value_reg <= state_next.err ? '0 : state_next.acc;
            out_bad_reg   <= state_next.err;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_bad_reg;

endmodule

FILE: src/b36_checker.sv
// ----------------------------------------------------------------------------
// b36_port_checker
// Port-level checks for the base-36 text decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b36_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Drop the value on error
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 64'd0)
        else $error("error result carries a nonzero value");

    // Clear the result slot on reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Accept input whenever the result slot is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result slot");

endmodule

bind base36_text_decoder b36_port_checker u_b36_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
